[rtl/bbct_pkg.sv]
// ----------------------------------------------------------------------------
// Block buffer cache tags package
// Shared constants, codes and cell interface types of the tag controller.
// ----------------------------------------------------------------------------
package bbct_pkg;

    localparam int NUM_ENTRIES       = 64;
    localparam int SECTORS_PER_BLOCK = 2;
    localparam int REF_WIDTH         = 8;

    localparam int IDX_W    = $clog2(NUM_ENTRIES);
    localparam int LVL_W    = $clog2(NUM_ENTRIES + 1);
    localparam int DEV_W    = 8;
    localparam int BLK_W    = 32;
    localparam int SEC_W    = 36;
    localparam int ENTRY_W  = 6;

    localparam logic [REF_WIDTH-1:0] REF_MAX = {REF_WIDTH{1'b1}};

    // Result status codes.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_UNUSED  = 2'd2;
    localparam logic [1:0] ST_SAT     = 2'd3;

    // Device operation codes.
    localparam logic [1:0] OP_NONE  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;

    // Request function codes.
    localparam logic FN_ACQUIRE = 1'b0;
    localparam logic FN_RELEASE = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_DECIDE,
        S_RESULT
    } t_state;

    // Command broadcast from the controller to every cell.
    typedef struct packed {
        logic             write;   // install a new tag, count one
        logic             inc;     // count up
        logic             dec;     // count down, drop live at zero
        logic [IDX_W-1:0] sel;     // target entry
        logic [DEV_W-1:0] dev;
        logic [BLK_W-1:0] blk;
    } t_cell_cmd;

    // Match information travelling down the row of cells.
    typedef struct packed {
        logic                 found;
        logic [IDX_W-1:0]     idx;
        logic [REF_WIDTH-1:0] refs;
        logic [DEV_W-1:0]     dev;
        logic [BLK_W-1:0]     blk;
    } t_chain;

    // Scale a block number to its first sector.
    function automatic logic [SEC_W-1:0] sector_of(input logic [BLK_W-1:0] blk);
        logic [SEC_W+4:0] prod;
        prod = {{(SEC_W+5-BLK_W){1'b0}}, blk} * (SEC_W+5)'(SECTORS_PER_BLOCK);
        return prod[SEC_W-1:0];
    endfunction

endpackage

[rtl/bbct_cell.sv]
// ----------------------------------------------------------------------------
// Tag cell
// Holds one entry's tag, live bit and count; adds its match to the chain.
// ----------------------------------------------------------------------------
module bbct_cell (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [bbct_pkg::IDX_W-1:0]    i_my_idx,
    input  logic                          i_search,
    input  logic [bbct_pkg::IDX_W-1:0]    i_query_idx,
    input  bbct_pkg::t_cell_cmd           i_cmd,
    input  bbct_pkg::t_chain              i_chain,
    output bbct_pkg::t_chain              o_chain
);

    logic                             r_live;
    logic [bbct_pkg::REF_WIDTH-1:0]   r_refs;
    logic [bbct_pkg::DEV_W-1:0]       r_dev;
    logic [bbct_pkg::BLK_W-1:0]       r_blk;
    logic                             w_sel;

    assign w_sel = (i_cmd.sel == i_my_idx);

    // Control state: live bit and count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live <= 1'b0;
            r_refs <= '0;
        end else if (w_sel) begin
            if (i_cmd.write) begin
                r_live <= 1'b1;
                r_refs <= bbct_pkg::REF_WIDTH'(1);
            end else if (i_cmd.inc) begin
                r_refs <= r_refs + 1'b1;
            end else if (i_cmd.dec) begin
                r_refs <= r_refs - 1'b1;
                if (r_refs == bbct_pkg::REF_WIDTH'(1)) begin
                    r_live <= 1'b0;
                end
            end
        end
    end

    // Tag storage, written on install only.
    always_ff @(posedge i_clk) begin
        if (w_sel && i_cmd.write) begin
            r_dev <= i_cmd.dev;
            r_blk <= i_cmd.blk;
        end
    end

    // In search mode a tag match claims the chain; in index mode the
    // addressed cell drops its contents in. The first claim wins.
    always_comb begin
        o_chain = i_chain;
        if (!i_chain.found) begin
            if (i_search ? (r_live && r_dev == i_cmd.dev && r_blk == i_cmd.blk)
                         : (i_query_idx == i_my_idx)) begin
                o_chain.found = 1'b1;
                o_chain.idx   = i_my_idx;
                o_chain.refs  = r_refs;
                o_chain.dev   = r_dev;
                o_chain.blk   = r_blk;
            end
        end
    end

endmodule

[rtl/bbct_row.sv]
// ----------------------------------------------------------------------------
// Cell row
// Chains the tag cells and registers the chain's end for the controller.
// ----------------------------------------------------------------------------
module bbct_row (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_search,
    input  logic [bbct_pkg::IDX_W-1:0]    i_query_idx,
    input  bbct_pkg::t_cell_cmd           i_cmd,
    output bbct_pkg::t_chain              o_result
);

    bbct_pkg::t_chain w_chain [bbct_pkg::NUM_ENTRIES+1];
    bbct_pkg::t_chain r_result;

    assign w_chain[0] = '0;

    for (genvar g = 0; g < bbct_pkg::NUM_ENTRIES; g++) begin : g_cell
        bbct_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_my_idx    (bbct_pkg::IDX_W'(g)),
            .i_search    (i_search),
            .i_query_idx (i_query_idx),
            .i_cmd       (i_cmd),
            .i_chain     (w_chain[g]),
            .o_chain     (w_chain[g+1])
        );
    end

    // Register the chain output ahead of the decision.
    always_ff @(posedge i_clk) begin
        r_result <= w_chain[bbct_pkg::NUM_ENTRIES];
    end

    assign o_result = r_result;

endmodule

[rtl/block_buffer_cache_tags_unit.sv]
// ----------------------------------------------------------------------------
// Block buffer cache tags unit
// Tag match, reference counts and free queue of a disk block buffer cache.
// ----------------------------------------------------------------------------
// A request accepted at a start edge passes through the search, decide and
// result states, with its result strobe in the result state; busy drops when
// the strobe ends, so a new request is taken only after the previous one is done.
// The row of tag cells is searched and its result registered,
// then counts and the free queue are updated. The receiver cannot stall.
// Reset clears live bits, counts and queue pointers at once; no sweep.
module block_buffer_cache_tags_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_func,
    input  logic [7:0]  i_device_id,
    input  logic [31:0] i_block_number,
    input  logic [5:0]  i_entry_index,
    input  logic        i_was_modified,
    output logic        o_valid,
    output logic [1:0]  o_status,
    output logic        o_hit,
    output logic [5:0]  o_result_entry,
    output logic [1:0]  o_device_op,
    output logic [7:0]  o_op_device,
    output logic [35:0] o_op_sector
);

    localparam int IW = bbct_pkg::IDX_W;
    localparam int LW = bbct_pkg::LVL_W;

    bbct_pkg::t_state r_state, n_state;

    logic                       r_func;
    logic [7:0]                 r_dev;
    logic [31:0]                r_blk;
    logic [5:0]                 r_idx;
    logic                       r_mod;

    logic [LW-1:0]              r_fresh, n_fresh;
    logic [IW-1:0]              r_head, n_head;
    logic [IW-1:0]              r_tail, n_tail;
    logic [LW-1:0]              r_level, n_level;
    logic [IW-1:0]              r_queue [bbct_pkg::NUM_ENTRIES];
    logic [IW-1:0]              r_qpick;

    logic                       n_push;
    bbct_pkg::t_cell_cmd        w_cmd;
    bbct_pkg::t_chain           w_res;
    logic                       w_idx_ok;

    logic                       r_valid, n_valid;
    logic [1:0]                 r_status, n_status;
    logic                       r_hit, n_hit;
    logic [5:0]                 r_entry, n_entry;
    logic [1:0]                 r_op, n_op;
    logic [7:0]                 r_opdev, n_opdev;
    logic [35:0]                r_opsec, n_opsec;

    assign w_idx_ok = ({{(32-6){1'b0}}, r_idx} < 32'(bbct_pkg::NUM_ENTRIES));

    bbct_row u_row (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_search    (r_func == bbct_pkg::FN_ACQUIRE),
        .i_query_idx (r_idx[IW-1:0]),
        .i_cmd       (w_cmd),
        .o_result    (w_res)
    );

    // Request capture on transfer.
    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_func <= i_func;
            r_dev  <= i_device_id;
            r_blk  <= i_block_number;
            r_idx  <= i_entry_index;
            r_mod  <= i_was_modified;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bbct_pkg::S_IDLE;
            r_fresh <= '0;
            r_head  <= '0;
            r_tail  <= '0;
            r_level <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fresh <= n_fresh;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_level <= n_level;
            r_valid <= n_valid;
        end
    end

    // Free queue storage with a registered head read, and result payload.
    always_ff @(posedge i_clk) begin
        if (n_push) begin
            r_queue[r_tail] <= r_idx[IW-1:0];
        end
        r_qpick  <= r_queue[r_head];
        r_status <= n_status;
        r_hit    <= n_hit;
        r_entry  <= n_entry;
        r_op     <= n_op;
        r_opdev  <= n_opdev;
        r_opsec  <= n_opsec;
    end

    // Sequencer: search, decide and update, then present the result.
    always_comb begin
        n_state  = r_state;
        n_fresh  = r_fresh;
        n_head   = r_head;
        n_tail   = r_tail;
        n_level  = r_level;
        n_push   = 1'b0;
        n_valid  = 1'b0;
        n_status = bbct_pkg::ST_OK;
        n_hit    = 1'b0;
        n_entry  = r_idx;
        n_op     = bbct_pkg::OP_NONE;
        n_opdev  = '0;
        n_opsec  = '0;
        w_cmd    = '0;
        w_cmd.dev = r_dev;
        w_cmd.blk = r_blk;
        unique case (r_state)
            bbct_pkg::S_IDLE: begin
                if (start) begin
                    n_state = bbct_pkg::S_SEARCH;
                end
            end
            bbct_pkg::S_SEARCH: begin
                n_state = bbct_pkg::S_DECIDE;
            end
            bbct_pkg::S_DECIDE: begin
                n_state = bbct_pkg::S_RESULT;
                n_valid = 1'b1;
                if (r_func == bbct_pkg::FN_ACQUIRE) begin
                    if (w_res.found) begin
                        n_hit   = 1'b1;
                        n_entry = 6'(w_res.idx);
                        if (w_res.refs == bbct_pkg::REF_MAX) begin
                            n_status = bbct_pkg::ST_SAT;
                        end else begin
                            w_cmd.inc = 1'b1;
                            w_cmd.sel = w_res.idx;
                        end
                    end else if (r_fresh < LW'(bbct_pkg::NUM_ENTRIES)) begin
                        w_cmd.write = 1'b1;
                        w_cmd.sel   = r_fresh[IW-1:0];
                        n_fresh     = r_fresh + 1'b1;
                        n_entry     = 6'(r_fresh[IW-1:0]);
                        n_op        = bbct_pkg::OP_READ;
                        n_opdev     = r_dev;
                        n_opsec     = bbct_pkg::sector_of(r_blk);
                    end else if (r_level != '0) begin
                        w_cmd.write = 1'b1;
                        w_cmd.sel   = r_qpick;
                        n_head      = (r_head == IW'(bbct_pkg::NUM_ENTRIES - 1)) ?
                                      '0 : r_head + 1'b1;
                        n_level     = r_level - 1'b1;
                        n_entry     = 6'(r_qpick);
                        n_op        = bbct_pkg::OP_READ;
                        n_opdev     = r_dev;
                        n_opsec     = bbct_pkg::sector_of(r_blk);
                    end else begin
                        n_status = bbct_pkg::ST_FULL;
                        n_entry  = '0;
                    end
                end else begin
                    if (!w_idx_ok || w_res.refs == '0) begin
                        n_status = bbct_pkg::ST_UNUSED;
                    end else begin
                        w_cmd.dec = 1'b1;
                        w_cmd.sel = r_idx[IW-1:0];
                        if (w_res.refs == bbct_pkg::REF_WIDTH'(1)) begin
                            if (r_level < LW'(bbct_pkg::NUM_ENTRIES)) begin
                                n_push  = 1'b1;
                                n_tail  = (r_tail == IW'(bbct_pkg::NUM_ENTRIES - 1)) ?
                                          '0 : r_tail + 1'b1;
                                n_level = r_level + 1'b1;
                            end
                            if (r_mod) begin
                                n_op    = bbct_pkg::OP_WRITE;
                                n_opdev = w_res.dev;
                                n_opsec = bbct_pkg::sector_of(w_res.blk);
                            end
                        end
                    end
                end
            end
            bbct_pkg::S_RESULT: begin
                n_state = bbct_pkg::S_IDLE;
            end
            default: begin
                n_state = bbct_pkg::S_IDLE;
            end
        endcase
    end

    assign busy           = (r_state != bbct_pkg::S_IDLE);
    assign o_valid        = r_valid;
    assign o_status       = r_status;
    assign o_hit          = r_hit;
    assign o_result_entry = r_entry;
    assign o_device_op    = r_op;
    assign o_op_device    = r_opdev;
    assign o_op_sector    = r_opsec;

    // Checks on the sequencer and free queue.
    a_valid_after_decide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_state) == bbct_pkg::S_DECIDE)
        else $error("result strobe without a decision");
    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_level <= LW'(bbct_pkg::NUM_ENTRIES))
        else $error("free queue level overflow");
    a_fresh_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fresh <= LW'(bbct_pkg::NUM_ENTRIES))
        else $error("fresh entry count overflow");
    a_hit_no_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_hit) |-> o_device_op == bbct_pkg::OP_NONE)
        else $error("hit issued a device operation");

endmodule
